// File: rtl/interrupt_controller_with_sub_sources_defines.svh
// Assertion macros for the interrupt controller RTL, used by icss_skid.
`ifndef INTERRUPT_CONTROLLER_WITH_SUB_SOURCES_DEFINES_SVH
`define INTERRUPT_CONTROLLER_WITH_SUB_SOURCES_DEFINES_SVH

// Clocked check, masked while reset is low.
`define ICSS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked check that also holds during reset.
`define ICSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/icss_pkg.sv
package icss_pkg;

    typedef enum logic [1:0] {
        ACT_READ       = 2'd0,
        ACT_WRITE      = 2'd1,
        ACT_RAISE_MAIN = 2'd2,
        ACT_RAISE_SUB  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_SRCPND    = 3'd0,
        REG_INTMOD    = 3'd1,
        REG_INTMSK    = 3'd2,
        REG_PRIORITY  = 3'd3,
        REG_INTPND    = 3'd4,
        REG_INTOFFSET = 3'd5,
        REG_SUBSRCPND = 3'd6,
        REG_INTSUBMSK = 3'd7
    } reg_sel_t;

    localparam int unsigned SUB_W = 15;

    localparam logic [SUB_W-1:0] SUB_ALL   = 15'h7fff;
    localparam logic [SUB_W-1:0] SUB_PORT0 = 15'h0007;
    localparam logic [SUB_W-1:0] SUB_PORT1 = 15'h0038;
    localparam logic [SUB_W-1:0] SUB_PORT2 = 15'h01c0;
    localparam logic [SUB_W-1:0] SUB_CONV  = 15'h0600;

    typedef struct packed {
        logic [31:0] read_data;
        logic        fiq_request;
        logic        irq_request;
    } result_t;

    // Bit number of a one-hot word (zero when the word is zero).
    function automatic logic [4:0] onehot_index(input logic [31:0] oh);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (oh[i]) begin
                idx = idx | 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/icss_core.sv
module icss_core #(
    parameter int unsigned PORT0_BIT     = 28,
    parameter int unsigned PORT1_BIT     = 23,
    parameter int unsigned PORT2_BIT     = 15,
    parameter int unsigned CONVERTER_BIT = 31,
    parameter int unsigned TX_SUB_OFFSET = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [1:0]        action,
    input  logic [2:0]        reg_select,
    input  logic [31:0]       value,
    output icss_pkg::result_t result
);

    localparam logic [icss_pkg::SUB_W-1:0] TX_ONE  = icss_pkg::SUB_W'(1);
    localparam logic [icss_pkg::SUB_W-1:0] TX_BITS = (TX_ONE << TX_SUB_OFFSET)
        | (TX_ONE << (TX_SUB_OFFSET + 3)) | (TX_ONE << (TX_SUB_OFFSET + 6));

    logic [31:0] srcpnd_reg, srcpnd_next;
    logic [31:0] intmod_reg, intmod_next;
    logic [31:0] intmsk_reg, intmsk_next;
    logic [31:0] prio_reg, prio_next;
    logic [31:0] onehot_reg, onehot_next;
    logic [4:0]  offset_reg, offset_next;
    logic [icss_pkg::SUB_W-1:0] subpnd_reg, subpnd_next;
    logic [icss_pkg::SUB_W-1:0] submsk_reg, submsk_next;
    logic        fiq_reg, fiq_next;
    logic        irq_reg, irq_next;

    logic [31:0] low_oh;
    logic [4:0]  low_idx;
    logic [31:0] data;
    logic        do_update;
    logic [icss_pkg::SUB_W-1:0] sreq;
    logic [31:0] req;

    // Lowest pending source, isolated by a two's complement and.
    assign low_oh  = srcpnd_reg & (~srcpnd_reg + 32'd1);
    assign low_idx = icss_pkg::onehot_index(low_oh);

    always_comb begin
        srcpnd_next = srcpnd_reg;
        intmod_next = intmod_reg;
        intmsk_next = intmsk_reg;
        prio_next   = prio_reg;
        onehot_next = onehot_reg;
        offset_next = offset_reg;
        subpnd_next = subpnd_reg;
        submsk_next = submsk_reg;
        fiq_next    = fiq_reg;
        irq_next    = irq_reg;
        data        = 32'd0;
        do_update   = 1'b0;
        sreq        = '0;
        req         = '0;

        case (icss_pkg::action_t'(action))
            icss_pkg::ACT_READ: begin
                case (icss_pkg::reg_sel_t'(reg_select))
                    icss_pkg::REG_SRCPND:    data = srcpnd_reg;
                    icss_pkg::REG_INTMOD:    data = intmod_reg;
                    icss_pkg::REG_INTMSK:    data = intmsk_reg;
                    icss_pkg::REG_PRIORITY:  data = prio_reg;
                    icss_pkg::REG_INTPND,
                    icss_pkg::REG_INTOFFSET: begin
                        // Nothing pending: data stays 0, offset kept.
                        if (srcpnd_reg != 32'd0) begin
                            offset_next = low_idx;
                            if (reg_select == icss_pkg::REG_INTOFFSET) begin
                                data = {27'd0, low_idx};
                            end else begin
                                data = low_oh;
                            end
                        end
                        onehot_next = 32'd1 << offset_next;
                    end
                    icss_pkg::REG_SUBSRCPND: data = {17'd0, subpnd_reg};
                    default:                 data = {17'd0, submsk_reg};
                endcase
            end
            icss_pkg::ACT_WRITE: begin
                case (icss_pkg::reg_sel_t'(reg_select))
                    icss_pkg::REG_SRCPND:   srcpnd_next = srcpnd_reg & ~value;
                    icss_pkg::REG_INTMOD:   intmod_next = value;
                    icss_pkg::REG_INTMSK: begin
                        intmsk_next = value;
                        do_update   = 1'b1;
                    end
                    icss_pkg::REG_PRIORITY: prio_next = value;
                    icss_pkg::REG_INTPND: begin
                        onehot_next = onehot_reg & ~value;
                        offset_next = 5'd0;
                    end
                    icss_pkg::REG_INTOFFSET: ;
                    icss_pkg::REG_SUBSRCPND:
                        subpnd_next = subpnd_reg & ~value[icss_pkg::SUB_W-1:0];
                    default: submsk_next = value[icss_pkg::SUB_W-1:0];
                endcase
            end
            icss_pkg::ACT_RAISE_MAIN: begin
                srcpnd_next = srcpnd_reg | value;
                do_update   = 1'b1;
            end
            default: begin
                subpnd_next = subpnd_reg | value[icss_pkg::SUB_W-1:0];
                do_update   = 1'b1;
            end
        endcase

        if (do_update) begin
            subpnd_next = (subpnd_next | TX_BITS) & icss_pkg::SUB_ALL;
            sreq = subpnd_next & ~submsk_next;
            if ((sreq & icss_pkg::SUB_PORT0) != '0) srcpnd_next[PORT0_BIT] = 1'b1;
            if ((sreq & icss_pkg::SUB_PORT1) != '0) srcpnd_next[PORT1_BIT] = 1'b1;
            if ((sreq & icss_pkg::SUB_PORT2) != '0) srcpnd_next[PORT2_BIT] = 1'b1;
            if ((sreq & icss_pkg::SUB_CONV) != '0)  srcpnd_next[CONVERTER_BIT] = 1'b1;
            req      = srcpnd_next & ~intmsk_next;
            fiq_next = |(req & intmod_next);
            irq_next = |(req & ~intmod_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srcpnd_reg <= 32'd0;
            intmod_reg <= 32'd0;
            intmsk_reg <= 32'hffff_ffff;
            prio_reg   <= 32'd0;
            onehot_reg <= 32'd0;
            offset_reg <= 5'd0;
            subpnd_reg <= '0;
            submsk_reg <= '0;
            fiq_reg    <= 1'b0;
            irq_reg    <= 1'b0;
        end else if (accept) begin
            srcpnd_reg <= srcpnd_next;
            intmod_reg <= intmod_next;
            intmsk_reg <= intmsk_next;
            prio_reg   <= prio_next;
            onehot_reg <= onehot_next;
            offset_reg <= offset_next;
            subpnd_reg <= subpnd_next;
            submsk_reg <= submsk_next;
            fiq_reg    <= fiq_next;
            irq_reg    <= irq_next;
        end
    end

    assign result.read_data   = data;
    assign result.fiq_request = fiq_next;
    assign result.irq_request = irq_next;

endmodule

// File: rtl/icss_skid.sv
`include "interrupt_controller_with_sub_sources_defines.svh"

module icss_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  icss_pkg::result_t in_data,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output icss_pkg::result_t out_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    icss_pkg::result_t main_reg, main_next;
    icss_pkg::result_t skid_reg, skid_next;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else if (in_valid) begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end else begin
                main_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    `ICSS_ASSERT_ALWAYS(a_skid_behind_main, aclk, skid_valid_reg |-> main_valid_reg, "skid full with main empty")
    `ICSS_ASSERT(a_no_push_when_full, aclk, aresetn, skid_valid_reg |-> !in_valid, "beat pushed into full buffer")
    `ICSS_ASSERT(a_stall_fills_skid, aclk, aresetn, (in_valid && main_valid_reg && !out_ready) |=> skid_valid_reg, "stalled beat not parked")

endmodule

// File: rtl/interrupt_controller_with_sub_sources.sv
// Interrupt controller with sub-source pending, one beat in and one result beat
// out per register access or source raise. A beat is accepted in every cycle
// while s_ready is high; its register read, write or raise is applied to the
// controller state in the accept cycle, and the result beat is registered in
// the output buffer before it appears on the m_ side. Reads of intpnd/intoffset
// pick the lowest pending source; writes to srcpnd, intpnd and subsrcpnd clear
// the bits written as ones; an intmsk write or a raise reruns the request update
// and refreshes the fiq/irq lines reported with every result. Throughput is one
// beat per cycle while m_ready takes the results; a two-entry output buffer lets
// one more beat in while a result stalls, and s_ready drops only when both hold.
module interrupt_controller_with_sub_sources #(
    parameter int unsigned PORT0_BIT     = 28,
    parameter int unsigned PORT1_BIT     = 23,
    parameter int unsigned PORT2_BIT     = 15,
    parameter int unsigned CONVERTER_BIT = 31,
    parameter int unsigned TX_SUB_OFFSET = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [2:0]  s_reg_select,
    input  logic [31:0] s_value,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_fiq_request,
    output logic        m_irq_request
);

    logic              accept;
    icss_pkg::result_t core_result;
    icss_pkg::result_t out_result;

    // State moves only on an accepted beat.
    assign accept = s_valid && s_ready;

    icss_core #(
        .PORT0_BIT     (PORT0_BIT),
        .PORT1_BIT     (PORT1_BIT),
        .PORT2_BIT     (PORT2_BIT),
        .CONVERTER_BIT (CONVERTER_BIT),
        .TX_SUB_OFFSET (TX_SUB_OFFSET)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .action     (s_action),
        .reg_select (s_reg_select),
        .value      (s_value),
        .result     (core_result)
    );

    // Result register plus skid entry; s_ready comes straight from a flop.
    icss_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_data   (core_result),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_read_data   = out_result.read_data;
    assign m_fiq_request = out_result.fiq_request;
    assign m_irq_request = out_result.irq_request;

endmodule

// File: test/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import icss_pkg::*;

    // Fold positions and TX sub-source offset, same as the DUT defaults
    localparam int unsigned PORT0_BIT     = 28;
    localparam int unsigned PORT1_BIT     = 23;
    localparam int unsigned PORT2_BIT     = 15;
    localparam int unsigned CONVERTER_BIT = 31;
    localparam int unsigned TX_SUB_OFFSET = 1;

    localparam int unsigned RANDOM_BEATS = 1600;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 80;

    // One request beat as it goes into the queue of pending stimulus
    typedef struct {
        action_t     act;
        reg_sel_t    sel;
        logic [31:0] value;
    } req_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = '0;
    logic [2:0]  s_reg_select = '0;
    logic [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_read_data;
    logic        m_fiq_request;
    logic        m_irq_request;

    interrupt_controller_with_sub_sources u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_reg_select  (s_reg_select),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_fiq_request (m_fiq_request),
        .m_irq_request (m_irq_request)
    );

    // Stimulus waiting for the driver, and the results the controller owes us
    req_beat_t   pending_beats[$];
    result_t     owed_results[$];

    int unsigned err_count    = 0;
    int unsigned beats_in     = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count  = 0;
    int unsigned n_stim       = 0;
    int unsigned act_count[4] = '{default: 0};
    int unsigned served_hits  = 0;
    int unsigned fiq_seen     = 0;
    int unsigned irq_seen     = 0;
    bit          in_taken     = 1'b0;

    // ------------------------------------------------------------------
    // Controller shadow state
    // ------------------------------------------------------------------
    logic [31:0]      src_pend;
    logic [31:0]      mode_bits;
    logic [31:0]      src_mask;
    logic [31:0]      prio_word;
    logic [31:0]      served_oh;
    logic [4:0]       served_off;
    logic [SUB_W-1:0] sub_pend;
    logic [SUB_W-1:0] sub_msk;
    logic             fiq_q;
    logic             irq_q;

    function automatic void clear_shadow();
        src_pend   = '0;
        mode_bits  = '0;
        src_mask   = '1;
        prio_word  = '0;
        served_oh  = '0;
        served_off = '0;
        sub_pend   = '0;
        sub_msk    = '0;
        fiq_q      = 1'b0;
        irq_q      = 1'b0;
    endfunction

    // Mask write or raise: force the three TX sub bits, fold unmasked
    // sub-requests into main sources, then split requests by mode.
    function automatic void refresh_lines();
        logic [SUB_W-1:0] tx;
        logic [SUB_W-1:0] sreq;
        logic [31:0]      req;
        tx = SUB_W'(1) << TX_SUB_OFFSET;
        sub_pend = sub_pend | tx | (tx << 3) | (tx << 6);
        sreq = sub_pend & ~sub_msk;
        if (|(sreq & SUB_PORT0)) src_pend[PORT0_BIT] = 1'b1;
        if (|(sreq & SUB_PORT1)) src_pend[PORT1_BIT] = 1'b1;
        if (|(sreq & SUB_PORT2)) src_pend[PORT2_BIT] = 1'b1;
        if (|(sreq & SUB_CONV))  src_pend[CONVERTER_BIT] = 1'b1;
        req   = src_pend & ~src_mask;
        fiq_q = |(req & mode_bits);
        irq_q = |(req & ~mode_bits);
    endfunction

    // intpnd / intoffset read: lowest pending source wins. With nothing
    // pending the old offset stays and the one-hot is rebuilt from it.
    function automatic logic [31:0] take_lowest_pending(bit want_offset);
        logic [31:0] data;
        int          idx;
        data = '0;
        idx  = -1;
        for (int i = 0; i < 32; i++) begin
            if (src_pend[i] && idx < 0) idx = i;
        end
        if (idx >= 0) begin
            served_off = 5'(idx);
            data = want_offset ? 32'(idx) : (32'(1) << idx);
            served_hits++;
        end
        served_oh = 32'(1) << served_off;
        return data;
    endfunction

    function automatic result_t predict_result(req_beat_t b);
        logic [31:0] rd;
        result_t     r;
        rd = '0;
        act_count[b.act]++;
        case (b.act)
            ACT_READ: begin
                case (b.sel)
                    REG_SRCPND:    rd = src_pend;
                    REG_INTMOD:    rd = mode_bits;
                    REG_INTMSK:    rd = src_mask;
                    REG_PRIORITY:  rd = prio_word;
                    REG_INTPND:    rd = take_lowest_pending(1'b0);
                    REG_INTOFFSET: rd = take_lowest_pending(1'b1);
                    REG_SUBSRCPND: rd = 32'(sub_pend);
                    default:       rd = 32'(sub_msk);
                endcase
            end
            ACT_WRITE: begin
                case (b.sel)
                    REG_SRCPND:    src_pend = src_pend & ~b.value;
                    REG_INTMOD:    mode_bits = b.value;
                    REG_INTMSK: begin
                        src_mask = b.value;
                        refresh_lines();
                    end
                    REG_PRIORITY:  prio_word = b.value;
                    REG_INTPND: begin
                        served_oh  = served_oh & ~b.value;
                        served_off = '0;
                    end
                    REG_INTOFFSET: ;  // read-only, write dropped
                    REG_SUBSRCPND: sub_pend = sub_pend & ~b.value[SUB_W-1:0];
                    default:       sub_msk = b.value[SUB_W-1:0];
                endcase
            end
            ACT_RAISE_MAIN: begin
                src_pend = src_pend | b.value;
                refresh_lines();
            end
            default: begin
                sub_pend = sub_pend | b.value[SUB_W-1:0];
                refresh_lines();
            end
        endcase
        r.read_data   = rd;
        r.fiq_request = fiq_q;
        r.irq_request = irq_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_beat(action_t act, reg_sel_t sel, logic [31:0] value);
        req_beat_t b;
        b.act   = act;
        b.sel   = sel;
        b.value = value;
        pending_beats.push_back(b);
        // a write to intoffset does nothing, so it does not count
        if (!(act == ACT_WRITE && sel == REG_INTOFFSET)) n_stim++;
    endfunction

    // Mix of dense, sparse, one-hot and the two extremes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return '1;
            2:       return 32'(1) << $urandom_range(0, 31);
            3:       return $urandom & $urandom;
            4:       return ~(32'(1) << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    function automatic reg_sel_t any_reg();
        return reg_sel_t'($urandom_range(0, 7));
    endfunction

    // Typical service flow: set up mode/sub masks, raise, unmask, find the
    // winner, then acknowledge. Content is random, order is well formed.
    function automatic void queue_service_flow();
        if ($urandom_range(0, 3) == 0) queue_beat(ACT_WRITE, REG_INTMOD, pick_word());
        if ($urandom_range(0, 2) == 0) queue_beat(ACT_WRITE, REG_INTSUBMSK, pick_word());
        if ($urandom_range(0, 1) == 0) queue_beat(ACT_RAISE_SUB, any_reg(), pick_word());
        else                           queue_beat(ACT_RAISE_MAIN, any_reg(), pick_word());
        if ($urandom_range(0, 1) == 0) queue_beat(ACT_WRITE, REG_INTMSK, pick_word());
        queue_beat(ACT_READ, REG_INTOFFSET, pick_word());
        queue_beat(ACT_READ, REG_INTPND, pick_word());
        repeat ($urandom_range(0, 2)) queue_beat(ACT_READ, any_reg(), pick_word());
        queue_beat(ACT_WRITE, REG_SRCPND, pick_word());
        if ($urandom_range(0, 1) == 0) queue_beat(ACT_WRITE, REG_SUBSRCPND, pick_word());
        queue_beat(ACT_WRITE, REG_INTPND, pick_word());
    endfunction

    function automatic int unsigned pick_gap(bit burst);
        int unsigned r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, cycle limit
    // ------------------------------------------------------------------
    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Hard stop if the handshakes ever lock up
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: cycle limit of %0d reached, %0d results still owed",
                 $time, CYCLE_LIMIT, owed_results.size());
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver: one beat held until accepted, gaps chosen per beat.
    // Changes only at the falling edge.
    // ------------------------------------------------------------------
    int unsigned tx_gap   = 0;
    bit          tx_burst = 1'b0;

    always @(negedge aclk) begin : drive_requests
        req_beat_t b;
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (tx_gap > 0) begin
                    s_valid <= 1'b0;
                    tx_gap--;
                end else if (pending_beats.size() > 0) begin
                    b = pending_beats.pop_front();
                    s_valid      <= 1'b1;
                    s_action     <= b.act;
                    s_reg_select <= b.sel;
                    s_value      <= b.value;
                    tx_gap = pick_gap(tx_burst);
                end else begin
                    s_valid <= 1'b0;
                end
                // occasionally switch between gappy and back-to-back traffic
                if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus a long hold-off twice in the run
    // so the output buffer fills and s_ready has to drop.
    // ------------------------------------------------------------------
    int unsigned rx_stall     = 0;
    int unsigned hold_left    = 0;
    int unsigned next_hold_at = 400;
    bit          rx_burst     = 1'b0;

    always @(negedge aclk) begin : drive_ready
        int unsigned r;
        if (aresetn) begin
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (results_seen >= next_hold_at) begin
                m_ready <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                next_hold_at += 700;
            end else if (rx_stall > 0) begin
                m_ready <= 1'b0;
                rx_stall--;
            end else if (rx_burst) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_ready <= 1'b1;
                end else if (r < 95) begin
                    m_ready <= 1'b0;
                    rx_stall = $urandom_range(0, 2);
                end else begin
                    m_ready <= 1'b0;
                    rx_stall = $urandom_range(8, 30);
                end
            end
            if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted request beat, then check the
    // result beat (if any) against the oldest prediction. Predicting first
    // keeps this correct even for a same-edge result.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch_beats
        req_beat_t b;
        result_t   want;
        if (!aresetn) begin
            in_taken = 1'b0;
        end else begin
            in_taken = s_valid && s_ready;
            if (in_taken) begin
                b.act   = action_t'(s_action);
                b.sel   = reg_sel_t'(s_reg_select);
                b.value = s_value;
                owed_results.push_back(predict_result(b));
                beats_in++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_fiq_request) fiq_seen++;
                if (m_irq_request) irq_seen++;
                if (owed_results.size() == 0) begin
                    err_count++;
                    $display("%0t: result beat with nothing owed: read_data %h fiq %b irq %b",
                             $time, m_read_data, m_fiq_request, m_irq_request);
                end else begin
                    want = owed_results.pop_front();
                    if (m_read_data !== want.read_data) begin
                        err_count++;
                        $display("%0t: read_data expected %h got %h",
                                 $time, want.read_data, m_read_data);
                    end
                    if (m_fiq_request !== want.fiq_request) begin
                        err_count++;
                        $display("%0t: fiq_request expected %b got %b",
                                 $time, want.fiq_request, m_fiq_request);
                    end
                    if (m_irq_request !== want.irq_request) begin
                        err_count++;
                        $display("%0t: irq_request expected %b got %b",
                                 $time, want.irq_request, m_irq_request);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus build and end of run
    // ------------------------------------------------------------------
    initial begin : run_test
        int unsigned stop_at;
        clear_shadow();

        // Directed: every register read straight out of reset, including
        // intpnd/intoffset with nothing pending
        for (int i = 0; i < 8; i++) queue_beat(ACT_READ, reg_sel_t'(i), '0);
        queue_beat(ACT_WRITE, REG_INTOFFSET, '1);      // read-only, ignored
        queue_beat(ACT_READ, REG_INTOFFSET, '0);
        queue_beat(ACT_WRITE, REG_INTMOD, 32'h0000_ffff);
        queue_beat(ACT_WRITE, REG_INTMSK, '0);         // first update, TX bits fold in
        queue_beat(ACT_READ, REG_INTPND, '0);
        queue_beat(ACT_READ, REG_INTOFFSET, '0);
        queue_beat(ACT_WRITE, REG_INTPND, '1);         // ack clears offset
        queue_beat(ACT_RAISE_MAIN, REG_INTSUBMSK, '1);
        queue_beat(ACT_RAISE_SUB, REG_SRCPND, '1);     // only low 15 bits stick
        queue_beat(ACT_WRITE, REG_INTSUBMSK, '1);      // narrowed to 15 bits
        queue_beat(ACT_READ, REG_SUBSRCPND, '0);
        queue_beat(ACT_READ, REG_INTSUBMSK, '0);
        queue_beat(ACT_WRITE, REG_SUBSRCPND, '1);
        queue_beat(ACT_WRITE, REG_SRCPND, '1);         // no update, lines stay latched
        queue_beat(ACT_WRITE, REG_PRIORITY, '1);
        queue_beat(ACT_READ, REG_PRIORITY, '0);
        queue_beat(ACT_WRITE, REG_PRIORITY, '0);
        queue_beat(ACT_WRITE, REG_INTMSK, '1);         // everything masked again
        queue_beat(ACT_READ, REG_INTPND, '0);          // nothing pending

        // Random: mostly service flows, the rest loose beats of any kind
        stop_at = n_stim + RANDOM_BEATS;
        while (n_stim < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                queue_service_flow();
            end else begin
                queue_beat(action_t'($urandom_range(0, 3)), any_reg(), pick_word());
            end
        end

        // Wait for the last beat to go in, then for every result to come back
        @(posedge aclk);
        while (pending_beats.size() != 0 || s_valid || !aresetn) @(posedge aclk);
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (owed_results.size() != 0) begin
            err_count++;
            $display("%0t: %0d results never arrived", $time, owed_results.size());
        end

        $display("summary: %0d request beats (%0d reads, %0d writes, %0d main raises, %0d sub raises)",
                 beats_in, act_count[ACT_READ], act_count[ACT_WRITE],
                 act_count[ACT_RAISE_MAIN], act_count[ACT_RAISE_SUB]);
        $display("summary: %0d results checked, %0d served reads found a source, fiq %0d irq %0d",
                 results_seen, served_hits, fiq_seen, irq_seen);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/icss_pkg.sv
rtl/icss_core.sv
rtl/icss_skid.sv
rtl/interrupt_controller_with_sub_sources.sv
test/tb_top.sv
